### rtl/bdra_pkg.sv
// shared types and constants for the bounded-denominator ratio approximation unit
`default_nettype none

package bdra_pkg;

  // fixed widths of the item fields on the ports
  localparam int FIELD_W    = 64;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic start_div;   // clear divider and product accumulators
    logic div_step;    // one restoring-division / horner bit
    logic update;      // form the next convergent, move to the next remainder
    logic out_load;    // write the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic small_zero;  // smaller component is zero
    logic rem_zero;    // current remainder is zero
    logic q_over;      // convergent denominator above the limit
    logic div_last;    // last bit of the current division
  } sts_t;

endpackage

`default_nettype wire

### rtl/bdra_dp.sv
// datapath: bit-serial divider with horner accumulators and convergent registers
`default_nettype none

module bdra_dp #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                       clk,
  input  wire bdra_pkg::cmd_t             cmd,
  output bdra_pkg::sts_t                  sts,
  input  wire logic [bdra_pkg::FIELD_W-1:0] in_num,
  input  wire logic [bdra_pkg::FIELD_W-1:0] in_den,
  input  wire logic [bdra_pkg::FIELD_W-1:0] in_lim,
  output logic [bdra_pkg::FIELD_W-1:0]    out_num,
  output logic [bdra_pkg::FIELD_W-1:0]    out_den,
  output logic                            out_invalid
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS);
  localparam int FW = bdra_pkg::FIELD_W;

  logic [W-1:0]  dvd;      // dividend, shifted out msb first
  logic [W-1:0]  dvs;      // divisor
  logic [W-1:0]  rem;      // partial remainder
  logic [W-1:0]  p;
  logic [W-1:0]  q;
  logic [W-1:0]  pp;
  logic [W-1:0]  qp;
  logic [W-1:0]  accp;     // k * p built one quotient bit at a time
  logic [W-1:0]  accq;     // k * q
  logic [W-1:0]  lim;
  logic          flip;
  logic          small_zero;
  logic          invalid;
  logic [CW-1:0] cnt;

  logic [W-1:0]  a_in;
  logic [W-1:0]  b_in;
  logic          flip_in;
  logic [W-1:0]  small_in;
  logic [W-1:0]  large_in;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic          use_prev;
  logic [W-1:0]  res_p;
  logic [W-1:0]  res_q;
  logic [W-1:0]  res_num;
  logic [W-1:0]  res_den;

  always_comb begin
    a_in     = in_num[W-1:0];
    b_in     = in_den[W-1:0];
    flip_in  = a_in > b_in;
    small_in = flip_in ? b_in : a_in;
    large_in = flip_in ? a_in : b_in;
  end

  // restoring division step
  always_comb begin
    trial = {rem, dvd[W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // fallback to the previous convergent, then orient to the input direction
  always_comb begin
    use_prev = !small_zero && (q > lim);
    res_p    = use_prev ? pp : p;
    res_q    = use_prev ? qp : q;
    if (flip && !invalid) begin
      res_num = res_q;
      res_den = res_p;
    end else begin
      res_num = res_p;
      res_den = res_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flip       <= flip_in;
      dvd        <= large_in;
      dvs        <= small_in;
      small_zero <= small_in == '0;
      invalid    <= (small_in == '0) && (large_in == '0);
      lim        <= in_lim[W-1:0];
      p          <= '0;
      q          <= W'(1);
      pp         <= W'(1);
      qp         <= '0;
    end
    if (cmd.start_div) begin
      cnt  <= '0;
      rem  <= '0;
      accp <= '0;
      accq <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? diff[W-1:0] : trial[W-1:0];
      dvd  <= {dvd[W-2:0], 1'b0};
      accp <= {accp[W-2:0], 1'b0} + (ge ? p : '0);
      accq <= {accq[W-2:0], 1'b0} + (ge ? q : '0);
      cnt  <= cnt + CW'(1);
    end
    if (cmd.update) begin
      p   <= accp + pp;
      pp  <= p;
      q   <= accq + qp;
      qp  <= q;
      dvd <= dvs;
      dvs <= rem;
    end
    if (cmd.out_load) begin
      out_num     <= FW'(res_num);
      out_den     <= FW'(res_den);
      out_invalid <= invalid;
    end
  end

  always_comb begin
    sts.small_zero = small_zero;
    sts.rem_zero   = dvs == '0;
    sts.q_over     = q > lim;
    sts.div_last   = cnt == CW'(W - 1);
  end

endmodule

`default_nettype wire

### rtl/bdra_ctrl.sv
// controller: sequences load, division steps, convergent updates and the result register
`default_nettype none

module bdra_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output bdra_pkg::cmd_t      cmd,
  input  wire bdra_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_NEXT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m_tvalid_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        // at least one quotient unless the smaller side is zero
        if (sts.small_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sts.rem_zero || sts.q_over) begin
          state_next = S_FIN;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register written while a result still waits");

  a_out_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result written but not presented");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken before the first was finished");

  a_update_after_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && sts.div_last) |=> cmd.update)
    else $error("convergent update missing after last division bit");

  a_update_only_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $past(cmd.div_step))
    else $error("convergent update without a finished division");
`endif

endmodule

`default_nettype wire

### rtl/bounded_denominator_ratio_approx_unit.sv
// top level of the bounded-denominator best rational approximation unit
`default_nettype none

// usage
//   input channel s_*: one item is a ratio numerator/denominator plus the
//   largest allowed denominator of the reduced smaller-over-larger fraction
//   output channel m_*: one item per input, the approximating ratio and an
//   invalid flag (set for 0/0, result then 0/1)
// operation
//   the smaller-over-larger fraction is expanded as a continued fraction;
//   each partial quotient comes from a bit-serial restoring divider that
//   also builds k*p and k*q msb first; one step runs the division bit by
//   bit, then one update, then one decision
// work per item
//   one step per partial quotient; with 64-bit words there are at most
//   about 93 of them; a zero component needs no division step; one item
//   is in work at a time
// reset
//   rst (synchronous) returns the controller to idle and drops m_tvalid
// stalls
//   the result sits in an output register; s_tready comes back as soon as
//   it is written, and a finished item waits there until m_tready is high

module bounded_denominator_ratio_approx_unit #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // numerator [63:0], denominator [127:64], max_den [191:128]
  input  wire logic [bdra_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // approx_num [63:0], approx_den [127:64]
  output logic [bdra_pkg::OUT_DATA_W-1:0]      m_tdata,
  // invalid [0]
  output logic                                 m_tuser
);

  localparam int FW = bdra_pkg::FIELD_W;

  bdra_pkg::cmd_t cmd;
  bdra_pkg::sts_t sts;
  logic [FW-1:0]  out_num;
  logic [FW-1:0]  out_den;
  logic           out_invalid;

  // sequencing and handshakes
  bdra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // divider, convergents and result register
  bdra_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .in_num      (s_tdata[FW-1:0]),
    .in_den      (s_tdata[2*FW-1:FW]),
    .in_lim      (s_tdata[3*FW-1:2*FW]),
    .out_num     (out_num),
    .out_den     (out_den),
    .out_invalid (out_invalid)
  );

  assign m_tdata = {out_den, out_num};
  assign m_tuser = out_invalid;

endmodule

`default_nettype wire
